// File: design/nv12_letterbox_resize_to_rgb_defines.svh
// Assertion macros for the NV12 letterbox resizer.
// Used by the modules that carry concurrent checks; needs clk and rst in scope.
`ifndef NV12_LETTERBOX_RESIZE_TO_RGB_DEFINES_SVH
`define NV12_LETTERBOX_RESIZE_TO_RGB_DEFINES_SVH

// expression must never hold
`define NLR_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("nlr: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define NLR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nlr: implication failed");

// antecedent implies consequent in the next cycle
`define NLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nlr: next-cycle implication failed");

`endif

// File: design/nlr_pkg.sv
// Shared types, constants and helpers of the NV12 letterbox resizer.
// No dependencies; every design module and the testbench import it.
package nlr_pkg;

  localparam int unsigned MAX_WIDTH    = 640;
  localparam int unsigned MAX_HEIGHT   = 480;
  localparam int unsigned MAX_OUT_SIZE = 640;
  localparam int unsigned STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
  localparam int unsigned DIV_BITS     = 27;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_BITS);

  localparam logic [7:0] PAD_GREY = 8'd114;

  localparam logic signed [16:0] K_Y  = 17'sd19077;
  localparam logic signed [16:0] K_RV = 17'sd26149;
  localparam logic signed [16:0] K_GU = 17'sd6419;
  localparam logic signed [16:0] K_GV = 17'sd13320;
  localparam logic signed [16:0] K_BU = 17'sd33050;

  localparam logic signed [25:0] Y_OFS = 26'sd1048576;
  localparam logic signed [25:0] C_OFS = 26'sd8388608;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_OUT_SIZE
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_BAD,
    CMD_PIX
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [18:0] addr;
    logic [7:0]  data;
    logic [9:0]  ox;
    logic [9:0]  oy;
  } cmd_t;

  typedef struct packed {
    logic [9:0] src_width;
    logic [8:0] src_height;
    logic [9:0] out_size;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FITW,
    ST_FITH,
    ST_PLACE,
    ST_SX,
    ST_SY,
    ST_COORD,
    ST_ROWS,
    ST_READ,
    ST_CONV,
    ST_FINISH,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] to_byte(input logic signed [43:0] q);
    logic signed [43:0] r;
    begin
      r = (q + 44'sd536870912) >>> 30;
      if (q <= 44'sd0) return 8'd0;
      if (r > 44'sd255) return 8'd255;
      return r[7:0];
    end
  endfunction

endpackage

// File: design/nlr_ifs.sv
// Channel interfaces of the NV12 letterbox resizer: request in, pixel out, config.
// Stand-alone; no package needed.
interface nlr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [18:0] byte_address;
  logic [7:0]  byte_value;
  logic [9:0]  out_x;
  logic [9:0]  out_y;
  modport source(output valid, mode, byte_address, byte_value, out_x, out_y, input ready);
  modport sink(input valid, mode, byte_address, byte_value, out_x, out_y, output ready);
endinterface

interface nlr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       pad_pixel;
  logic       config_bad;
  modport source(output valid, red, green, blue, pad_pixel, config_bad, input ready);
  modport sink(input valid, red, green, blue, pad_pixel, config_bad, output ready);
endinterface

interface nlr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: design/nlr_front.sv
// Front end: accepts requests and classifies them as load, bad-config or pixel.
// Depends on nlr_pkg and nlr_in_if.
module nlr_front (
  nlr_in_if.sink         src,
  input  nlr_pkg::cfg_t  cfg,
  input  logic           full,
  output logic           push,
  output nlr_pkg::cmd_t  cmd
);
  import nlr_pkg::*;

  logic bad;

  always_comb begin
    bad = (cfg.src_width < 10'd2) || cfg.src_width[0] ||
          (cfg.src_width > 10'(MAX_WIDTH)) ||
          (cfg.src_height < 9'd2) || cfg.src_height[0] ||
          ({1'b0, cfg.src_height} > 10'(MAX_HEIGHT)) ||
          (cfg.out_size == 10'd0) || (cfg.out_size > 10'(MAX_OUT_SIZE));
    cmd.addr = src.byte_address;
    cmd.data = src.byte_value;
    cmd.ox   = src.out_x;
    cmd.oy   = src.out_y;
    if (!src.mode) begin
      cmd.kind = CMD_LOAD;
    end else if (bad) begin
      cmd.kind = CMD_BAD;
    end else begin
      cmd.kind = CMD_PIX;
    end
  end

  assign src.ready = !full;
  assign push      = src.valid && !full;

endmodule

// File: design/nlr_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on nlr_pkg and the assertion macro header.
`include "nv12_letterbox_resize_to_rgb_defines.svh"
module nlr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nlr_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output nlr_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import nlr_pkg::*;

  cmd_t       ent [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= wr_cmd;
    end
  end

  assign head  = ent[rptr];
  assign full  = cnt == 2'd2;
  assign empty = cnt == 2'd0;

  `NLR_ASSERT_NEVER(a_q_count, cnt == 2'd3)
  `NLR_ASSERT_NEVER(a_q_pop_empty, pop && empty)

endmodule

// File: design/nlr_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on nlr_pkg and the assertion macro header.
`include "nv12_letterbox_resize_to_rgb_defines.svh"
module nlr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [26:0] num,
  input  logic [10:0] den,
  output logic        busy,
  output logic        done,
  output logic [26:0] quo
);
  import nlr_pkg::*;

  logic [26:0]          n;
  logic [10:0]          rem;
  logic [10:0]          dv;
  logic [DIV_CNT_W-1:0] cnt;
  logic [11:0]          trial;
  logic                 ge;

  assign trial = {rem, n[26]};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(DIV_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n   <= num;
      dv  <= den;
      rem <= 11'd0;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? 11'(trial - {1'b0, dv}) : trial[10:0];
      n   <= {n[25:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  assign quo = n;

  `NLR_ASSERT_IMPL(a_div_start_idle, start, !busy && den != 11'd0)

endmodule

// File: design/nlr_back.sv
// Back end: frame-store writes, fit, placement, coordinate mapping, bilinear
// reads, BT.601 conversion and the output register. Depends on nlr_pkg, nlr_div.
`include "nv12_letterbox_resize_to_rgb_defines.svh"
module nlr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  nlr_pkg::cmd_t head,
  input  nlr_pkg::cfg_t cfg,
  output logic          pop,
  nlr_out_if.source     dst
);
  import nlr_pkg::*;

  state_t state, state_next;

  logic [7:0]  mem [STORE_DEPTH];
  logic        we;
  logic [18:0] raddr;
  logic [7:0]  rdata;

  logic        div_start, div_busy, div_done;
  logic [26:0] div_num, div_quo;
  logic [10:0] div_den;
  logic [20:0] dmul;

  logic [9:0]  ox, oy, w, h, lx, ly;
  logic signed [18:0] sx, sy;
  logic [9:0]  x0, x1;
  logic [8:0]  y0, y1, cx0, cx1;
  logic [7:0]  fx, fy, cfx, cfy, cy0, cy1;
  logic [18:0] row0, row1, row2, row3, uvb;
  logic [3:0]  step;
  logic [23:0] acc_y, acc_u, acc_v;
  logic        rvalid_d;
  logic [1:0]  rsel_d;
  logic [16:0] wgt_d;
  logic signed [43:0] prod, ar, ag, ab;
  logic [7:0]  res_r, res_g, res_b;
  logic        res_pad, res_bad;
  logic        ovalid;

  logic [9:0]  mx, hw10;
  logic [8:0]  hw;
  logic [7:0]  hh;
  logic [9:0]  xp, yp;
  logic [10:0] xe, ye;
  logic        is_pad;
  logic [17:0] lim_x, sxp, syp, cqx;
  logic [16:0] lim_y, cqy, lim_cx, ccx, sxh, syh;
  logic [15:0] lim_cy, ccy;
  logic [18:0] rmul;
  logic [1:0]  j, grp;
  logic [18:0] lsum, csum;
  logic [8:0]  wx, wy;
  logic [17:0] wgt;
  logic signed [25:0] yd, ud, vd, cop;
  logic signed [16:0] coef;

  nlr_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(div_quo)
  );

  assign hw   = cfg.src_width[9:1];
  assign hw10 = {1'b0, hw};
  assign hh   = cfg.src_height[8:1];
  assign mx   = (cfg.src_width > {1'b0, cfg.src_height}) ? cfg.src_width
              : {1'b0, cfg.src_height};

  // divider operands
  always_comb begin
    dmul    = 21'd0;
    div_num = 27'd0;
    div_den = {mx, 1'b0};
    case (state)
      ST_FITW: begin
        dmul    = 21'(cfg.src_width * cfg.out_size);
        div_num = 27'({dmul, 1'b0}) + 27'(mx);
      end
      ST_FITH: begin
        dmul    = 21'(cfg.src_height * cfg.out_size);
        div_num = 27'({dmul, 1'b0}) + 27'(mx);
      end
      ST_SX: begin
        dmul    = 21'({lx, 1'b1} * cfg.src_width);
        div_num = {dmul[19:0], 7'd0};
        div_den = {1'b0, w};
      end
      ST_SY: begin
        dmul    = 21'({ly, 1'b1} * cfg.src_height);
        div_num = {dmul[19:0], 7'd0};
        div_den = {1'b0, h};
      end
      default: begin
      end
    endcase
  end

  // placement and coordinate clamps
  always_comb begin
    xp     = (cfg.out_size - w) >> 1;
    yp     = (cfg.out_size - h) >> 1;
    xe     = {1'b0, xp} + {1'b0, w};
    ye     = {1'b0, yp} + {1'b0, h};
    is_pad = (ox >= cfg.out_size) || (oy >= cfg.out_size) || (ox < xp) ||
             ({1'b0, ox} >= xe) || (oy < yp) || ({1'b0, oy} >= ye);
    lim_x  = {cfg.src_width - 10'd1, 8'd0};
    lim_y  = {cfg.src_height - 9'd1, 8'd0};
    lim_cx = {hw - 9'd1, 8'd0};
    lim_cy = {hh - 8'd1, 8'd0};
    sxp    = sx[18] ? 18'd0 : sx[17:0];
    syp    = sy[18] ? 18'd0 : sy[17:0];
    cqx    = (sxp > lim_x) ? lim_x : sxp;
    cqy    = (syp > {1'b0, lim_y}) ? lim_y : syp[16:0];
    sxh    = sxp[17:1];
    syh    = syp[17:1];
    ccx    = (sxh > lim_cx) ? lim_cx : sxh;
    ccy    = (syh > {1'b0, lim_cy}) ? lim_cy : syh[15:0];
  end

  // row products and read addresses
  always_comb begin
    case (step)
      4'd0:    rmul = 19'(y0 * cfg.src_width);
      4'd1:    rmul = 19'(y1 * cfg.src_width);
      4'd2:    rmul = 19'(cy0 * hw);
      4'd3:    rmul = 19'(cy1 * hw);
      default: rmul = 19'(cfg.src_height * cfg.src_width);
    endcase
    j    = step[1:0];
    grp  = step[3:2];
    lsum = (j[1] ? row1 : row0) + 19'(j[0] ? x1 : x0);
    csum = (j[1] ? row3 : row2) + 19'(j[0] ? cx1 : cx0);
    if (grp == 2'd0) begin
      raddr = lsum;
      wx = j[0] ? {1'b0, fx} : 9'd256 - {1'b0, fx};
      wy = j[1] ? {1'b0, fy} : 9'd256 - {1'b0, fy};
    end else begin
      raddr = uvb + {csum[17:0], 1'b0} + 19'(grp == 2'd2);
      wx = j[0] ? {1'b0, cfx} : 9'd256 - {1'b0, cfx};
      wy = j[1] ? {1'b0, cfy} : 9'd256 - {1'b0, cfy};
    end
    wgt = wx * wy;
  end

  // conversion operands
  always_comb begin
    yd = $signed({2'b00, acc_y}) - Y_OFS;
    ud = $signed({2'b00, acc_u}) - C_OFS;
    vd = $signed({2'b00, acc_v}) - C_OFS;
    case (step)
      4'd0:    begin coef = K_Y;  cop = yd; end
      4'd1:    begin coef = K_RV; cop = vd; end
      4'd2:    begin coef = K_GU; cop = ud; end
      4'd3:    begin coef = K_GV; cop = vd; end
      default: begin coef = K_BU; cop = ud; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    we         = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          case (head.kind)
            CMD_LOAD: we = head.addr < 19'(STORE_DEPTH);
            CMD_BAD:  state_next = ST_EMIT;
            CMD_PIX:  state_next = ST_FITW;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_FITW, ST_FITH, ST_SX, ST_SY: begin
        div_start = !div_busy && !div_done;
        if (div_done) begin
          case (state)
            ST_FITW: state_next = ST_FITH;
            ST_FITH: state_next = ST_PLACE;
            ST_SX:   state_next = ST_SY;
            default: state_next = ST_COORD;
          endcase
        end
      end
      ST_PLACE:  state_next = is_pad ? ST_EMIT : ST_SX;
      ST_COORD:  state_next = ST_ROWS;
      ST_ROWS:   if (step == 4'd4) state_next = ST_READ;
      ST_READ:   if (step == 4'd12) state_next = ST_CONV;
      ST_CONV:   if (step == 4'd5) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_EMIT;
      ST_EMIT:   if (!ovalid || dst.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[head.addr] <= head.data;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    rvalid_d <= (state == ST_READ) && (step < 4'd12);
    rsel_d   <= grp;
    wgt_d    <= wgt[16:0];
    prod     <= 44'(coef * cop);
    case (state)
      ST_IDLE: begin
        ox      <= head.ox;
        oy      <= head.oy;
        res_r   <= 8'd0;
        res_g   <= 8'd0;
        res_b   <= 8'd0;
        res_pad <= 1'b0;
        res_bad <= 1'b1;
      end
      ST_FITW: if (div_done) w <= (div_quo == 27'd0) ? 10'd1 : div_quo[9:0];
      ST_FITH: if (div_done) h <= (div_quo == 27'd0) ? 10'd1 : div_quo[9:0];
      ST_PLACE: begin
        lx      <= ox - xp;
        ly      <= oy - yp;
        res_r   <= PAD_GREY;
        res_g   <= PAD_GREY;
        res_b   <= PAD_GREY;
        res_pad <= 1'b1;
        res_bad <= 1'b0;
      end
      ST_SX: if (div_done) sx <= $signed({1'b0, div_quo[17:0]}) - 19'sd128;
      ST_SY: if (div_done) sy <= $signed({1'b0, div_quo[17:0]}) - 19'sd128;
      ST_COORD: begin
        x0    <= cqx[17:8];
        fx    <= cqx[7:0];
        x1    <= ({1'b0, cqx[17:8]} + 11'd1 < {1'b0, cfg.src_width}) ?
                 cqx[17:8] + 10'd1 : cfg.src_width - 10'd1;
        y0    <= cqy[16:8];
        fy    <= cqy[7:0];
        y1    <= ({1'b0, cqy[16:8]} + 10'd1 < {1'b0, cfg.src_height}) ?
                 cqy[16:8] + 9'd1 : cfg.src_height - 9'd1;
        cx0   <= ccx[16:8];
        cfx   <= ccx[7:0];
        cx1   <= ({1'b0, ccx[16:8]} + 10'd1 < hw10) ? ccx[16:8] + 9'd1 : hw - 9'd1;
        cy0   <= ccy[15:8];
        cfy   <= ccy[7:0];
        cy1   <= ({1'b0, ccy[15:8]} + 9'd1 < {1'b0, hh}) ? ccy[15:8] + 8'd1 : hh - 8'd1;
        acc_y <= 24'd0;
        acc_u <= 24'd0;
        acc_v <= 24'd0;
        step  <= 4'd0;
      end
      ST_ROWS: begin
        case (step)
          4'd0:    row0 <= rmul;
          4'd1:    row1 <= rmul;
          4'd2:    row2 <= rmul;
          4'd3:    row3 <= rmul;
          default: uvb  <= rmul;
        endcase
        step <= (step == 4'd4) ? 4'd0 : step + 4'd1;
      end
      ST_READ: begin
        step <= (step == 4'd12) ? 4'd0 : step + 4'd1;
      end
      ST_CONV: begin
        case (step)
          4'd1: begin ar <= prod; ag <= prod; ab <= prod; end
          4'd2: ar <= ar + prod;
          4'd3: ag <= ag - prod;
          4'd4: ag <= ag - prod;
          4'd5: ab <= ab + prod;
          default: begin
          end
        endcase
        step <= step + 4'd1;
      end
      ST_FINISH: begin
        res_r   <= to_byte(ar);
        res_g   <= to_byte(ag);
        res_b   <= to_byte(ab);
        res_pad <= 1'b0;
        res_bad <= 1'b0;
      end
      default: begin
      end
    endcase
    if (rvalid_d) begin
      case (rsel_d)
        2'd0:    acc_y <= acc_y + 24'(rdata * wgt_d);
        2'd1:    acc_u <= acc_u + 24'(rdata * wgt_d);
        default: acc_v <= acc_v + 24'(rdata * wgt_d);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == ST_EMIT && (!ovalid || dst.ready)) begin
      ovalid <= 1'b1;
    end else if (dst.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && (!ovalid || dst.ready)) begin
      dst.red        <= res_r;
      dst.green      <= res_g;
      dst.blue       <= res_b;
      dst.pad_pixel  <= res_pad;
      dst.config_bad <= res_bad;
    end
  end

  assign dst.valid = ovalid;

  `NLR_ASSERT_IMPL(a_fit_nonzero, state == ST_SX || state == ST_SY, w != 10'd0 && h != 10'd0)
  `NLR_ASSERT_NEXT(a_read_pipe, state == ST_READ && step < 4'd12, rvalid_d)

endmodule

// File: design/nv12_letterbox_resize_to_rgb.sv
// NV12 letterbox resize to RGB, BT.601 limited range, one pixel per request.
// Channels: src takes requests (mode 0 stores byte_value at byte_address in
// the frame store, mode 1 asks for pixel out_x, out_y of the square image);
// dst returns one RGB result per pixel request and nothing for a store; cfg
// writes src_width (index 0), src_height (1) and out_size (2), and is always
// ready. Write configuration only while no request is in flight.
// A store is queued and written to the frame store when the back end takes it.
// A pixel request passes four divisions on the shared one-bit-per-cycle divider,
// twelve reads through the single frame-store port and a five-product colour
// conversion. A padding pixel needs only the two fit divisions; a request under
// a bad configuration goes straight to the output register.
// A two-entry queue lets further requests be accepted while one is worked on.
// Reset restores 640, 480, 640 and empties queue and output; the frame store
// keeps its contents and is undefined until written. When dst stalls the
// result is held in the output register and the back end waits.
// Depends on nlr_pkg, nlr_ifs, nlr_front, nlr_queue, nlr_div and nlr_back.
module nv12_letterbox_resize_to_rgb (
  input logic       clk,
  input logic       rst,
  nlr_in_if.sink    src,
  nlr_out_if.source dst,
  nlr_cfg_if.sink   cfg
);
  import nlr_pkg::*;

  cfg_t cfg_regs;
  cmd_t push_cmd, head;
  logic push, pop, full, empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.src_width  <= 10'(MAX_WIDTH);
      cfg_regs.src_height <= 9'(MAX_HEIGHT);
      cfg_regs.out_size   <= 10'(MAX_OUT_SIZE);
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_SRC_WIDTH:  cfg_regs.src_width  <= cfg.data;
        REG_SRC_HEIGHT: cfg_regs.src_height <= cfg.data[8:0];
        REG_OUT_SIZE:   cfg_regs.out_size   <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  nlr_front u_front (
    .src(src), .cfg(cfg_regs), .full(full), .push(push), .cmd(push_cmd)
  );

  nlr_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_cmd(push_cmd), .pop(pop),
    .head(head), .full(full), .empty(empty)
  );

  nlr_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .head(head), .cfg(cfg_regs),
    .pop(pop), .dst(dst)
  );

endmodule

// File: verif/tb_nv12_letterbox_resize_to_rgb.sv
// Testbench for nv12_letterbox_resize_to_rgb: loads frame bytes, requests pixels and
// checks each RGB result against an in-bench letterbox/bilinear/BT.601 predictor.
// Depends on nlr_pkg, the nlr_ifs channel interfaces and the design sources.
`timescale 1ns / 1ps

module tb_nv12_letterbox_resize_to_rgb;
  import nlr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned TARGET_ITEMS   = 1900;
  localparam logic [1:0]  REG_NONE       = 2'd3;
  localparam int          TAP_BAD        = 0;
  localparam int          TAP_PAD        = 1;
  localparam int          TAP_PIX        = 2;

  typedef struct packed {
    logic        mode;
    logic [18:0] addr;
    logic [7:0]  value;
    logic [9:0]  ox;
    logic [9:0]  oy;
  } frame_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       pad;
    logic       bad;
  } rgb_pixel_t;

  typedef struct {
    int          kind;
    int unsigned a[12];
    int unsigned lfx, lfy, cfx, cfy;
  } tap_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nlr_in_if  src_if ();
  nlr_out_if dst_if ();
  nlr_cfg_if cfg_if ();

  nv12_letterbox_resize_to_rgb uut (
    .clk (clk),
    .rst (rst),
    .src (src_if),
    .dst (dst_if),
    .cfg (cfg_if)
  );

  always #2 clk = ~clk;

  logic [7:0]  frame_mem [STORE_DEPTH];
  bit          frame_seen [STORE_DEPTH];
  frame_req_t  pend_reqs [$];
  rgb_pixel_t  pixel_q [$];
  frame_req_t  cur;
  int unsigned cur_w = 640, cur_h = 480, cur_s = 640;
  int unsigned n_items = 0;
  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned cyc = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic        quiet;

  assign quiet = (cyc >= 30000) && (cyc < 45000);

  function automatic int unsigned fit_len(int unsigned len, int unsigned m, int unsigned s);
    longint unsigned v;
    v = (2 * longint'(len) * s + m) / (2 * longint'(m));
    return (v < 1) ? 1 : int'(v);
  endfunction

  function automatic int unsigned clamp_q8(longint c, int unsigned lim);
    longint top;
    top = longint'(lim - 1) * 256;
    if (c < 0) return 0;
    return (c > top) ? int'(top) : int'(c);
  endfunction

  function automatic tap_t locate_taps(int unsigned w, int unsigned h, int unsigned s,
                                       int unsigned ox, int unsigned oy);
    tap_t t;
    int unsigned m, fw, fh, xp, yp, cx, cy, hw, hh, base, x0, y0, x1, y1;
    longint sx, sy;
    t.kind = TAP_PIX;
    t.lfx = 0; t.lfy = 0; t.cfx = 0; t.cfy = 0;
    foreach (t.a[i]) t.a[i] = 0;
    if (w < 2 || h < 2 || w[0] || h[0] || w > MAX_WIDTH || h > MAX_HEIGHT ||
        s < 1 || s > MAX_OUT_SIZE) begin
      t.kind = TAP_BAD;
      return t;
    end
    m  = (w > h) ? w : h;
    fw = fit_len(w, m, s);
    fh = fit_len(h, m, s);
    xp = (s - fw) / 2;
    yp = (s - fh) / 2;
    if (ox >= s || oy >= s || ox < xp || ox >= xp + fw || oy < yp || oy >= yp + fh) begin
      t.kind = TAP_PAD;
      return t;
    end
    sx = longint'((2 * longint'(ox - xp) + 1) * w * 128 / fw) - 128;
    sy = longint'((2 * longint'(oy - yp) + 1) * h * 128 / fh) - 128;
    cx = clamp_q8(sx, w);
    cy = clamp_q8(sy, h);
    x0 = cx >> 8; y0 = cy >> 8;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    t.lfx = cx & 255; t.lfy = cy & 255;
    t.a[0] = y0 * w + x0; t.a[1] = y0 * w + x1;
    t.a[2] = y1 * w + x0; t.a[3] = y1 * w + x1;
    hw = w / 2; hh = h / 2;
    cx = clamp_q8((sx < 0) ? 0 : (sx >>> 1), hw);
    cy = clamp_q8((sy < 0) ? 0 : (sy >>> 1), hh);
    x0 = cx >> 8; y0 = cy >> 8;
    x1 = (x0 + 1 < hw) ? x0 + 1 : hw - 1;
    y1 = (y0 + 1 < hh) ? y0 + 1 : hh - 1;
    t.cfx = cx & 255; t.cfy = cy & 255;
    base = w * h;
    t.a[4] = base + (y0 * hw + x0) * 2; t.a[5] = base + (y0 * hw + x1) * 2;
    t.a[6] = base + (y1 * hw + x0) * 2; t.a[7] = base + (y1 * hw + x1) * 2;
    for (int i = 8; i < 12; i++) t.a[i] = t.a[i - 4] + 1;
    return t;
  endfunction

  function automatic longint bilerp(int unsigned p00, int unsigned p10, int unsigned p01,
                                    int unsigned p11, int unsigned fx, int unsigned fy);
    longint top, bot;
    top = longint'(256 - fx) * p00 + longint'(fx) * p10;
    bot = longint'(256 - fx) * p01 + longint'(fx) * p11;
    return longint'(256 - fy) * top + longint'(fy) * bot;
  endfunction

  function automatic logic [7:0] q30_to_u8(longint q);
    longint r;
    if (q <= 0) return 8'd0;
    r = (q + (longint'(1) << 29)) >>> 30;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic rgb_pixel_t render_pixel(logic [9:0] ox, logic [9:0] oy);
    rgb_pixel_t p;
    tap_t t;
    longint luma, cu, cv, l;
    p = '0;
    t = locate_taps(cur_w, cur_h, cur_s, ox, oy);
    if (t.kind == TAP_BAD) begin
      p.bad = 1'b1;
    end else if (t.kind == TAP_PAD) begin
      p.red = PAD_GREY; p.green = PAD_GREY; p.blue = PAD_GREY; p.pad = 1'b1;
    end else begin
      luma = bilerp(frame_mem[t.a[0]], frame_mem[t.a[1]], frame_mem[t.a[2]],
                    frame_mem[t.a[3]], t.lfx, t.lfy) - (longint'(16) << 16);
      cu = bilerp(frame_mem[t.a[4]], frame_mem[t.a[5]], frame_mem[t.a[6]],
                  frame_mem[t.a[7]], t.cfx, t.cfy) - (longint'(128) << 16);
      cv = bilerp(frame_mem[t.a[8]], frame_mem[t.a[9]], frame_mem[t.a[10]],
                  frame_mem[t.a[11]], t.cfx, t.cfy) - (longint'(128) << 16);
      l = 19077 * luma;
      p.red   = q30_to_u8(l + 26149 * cv);
      p.green = q30_to_u8(l - 6419 * cu - 13320 * cv);
      p.blue  = q30_to_u8(l + 33050 * cu);
    end
    return p;
  endfunction

  task automatic push_load(int unsigned a, int unsigned v);
    frame_req_t r;
    r = '0;
    r.mode = 1'b0; r.addr = a[18:0]; r.value = v[7:0];
    r.ox = 10'($urandom); r.oy = 10'($urandom);
    if (a < STORE_DEPTH) frame_seen[a] = 1'b1;
    pend_reqs.push_back(r);
    n_items++;
  endtask

  // fill < 0: load only taps never written, with random bytes
  task automatic push_pixel(int unsigned ox, int unsigned oy, int yfill, int cfill);
    frame_req_t r;
    tap_t t;
    int f;
    t = locate_taps(cur_w, cur_h, cur_s, ox, oy);
    if (t.kind == TAP_PIX) begin
      for (int i = 0; i < 12; i++) begin
        f = (i < 4) ? yfill : cfill;
        if (f >= 0) push_load(t.a[i], f);
        else if (!frame_seen[t.a[i]]) push_load(t.a[i], $urandom_range(0, 255));
      end
    end
    r = '0;
    r.mode = 1'b1; r.ox = ox[9:0]; r.oy = oy[9:0];
    r.addr = 19'($urandom); r.value = 8'($urandom);
    pend_reqs.push_back(r);
    n_items++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned s);
    write_reg(REG_SRC_WIDTH, w[9:0]);
    write_reg(REG_SRC_HEIGHT, h[9:0]);
    write_reg(REG_OUT_SIZE, s[9:0]);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pend_reqs.size() != 0 || src_if.valid || pixel_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic report(string what, int unsigned want, int unsigned got);
    $display("mismatch %s: expected %0d got %0d", what, want, got);
    n_errors++;
  endtask

  // feed requests from the pending queue, predict at acceptance
  always @(posedge clk) begin
    if (rst) begin
      src_if.valid <= 1'b0;
    end else begin
      if (src_if.valid && src_if.ready) begin
        if (!cur.mode) begin
          if (cur.addr < STORE_DEPTH) frame_mem[cur.addr] = cur.value;
        end else begin
          pixel_q.push_back(render_pixel(cur.ox, cur.oy));
        end
      end
      if (!src_if.valid || src_if.ready) begin
        if (pend_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 16)) begin
          cur = pend_reqs.pop_front();
          src_if.valid        <= 1'b1;
          src_if.mode         <= cur.mode;
          src_if.byte_address <= cur.addr;
          src_if.byte_value   <= cur.value;
          src_if.out_x        <= cur.ox;
          src_if.out_y        <= cur.oy;
        end else begin
          src_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        REG_SRC_WIDTH:  cur_w = 32'(cfg_if.data);
        REG_SRC_HEIGHT: cur_h = 32'(cfg_if.data[8:0]);
        REG_OUT_SIZE:   cur_s = 32'(cfg_if.data);
        default: ;
      endcase
    end
  end

  // hold off the result side once, long enough to back up the input
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && pend_reqs.size() > 40) begin
      hold_left <= 2500;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rgb_pixel_t want;
    if (rst) begin
      dst_if.ready <= 1'b0;
    end else begin
      if (dst_if.valid && dst_if.ready) begin
        if (pixel_q.size() == 0) begin
          report("unexpected pixel", 0, 1);
        end else begin
          want = pixel_q.pop_front();
          if (dst_if.red !== want.red) report("red", want.red, dst_if.red);
          if (dst_if.green !== want.green) report("green", want.green, dst_if.green);
          if (dst_if.blue !== want.blue) report("blue", want.blue, dst_if.blue);
          if (dst_if.pad_pixel !== want.pad) report("pad_pixel", want.pad, dst_if.pad_pixel);
          if (dst_if.config_bad !== want.bad) report("config_bad", want.bad, dst_if.config_bad);
        end
      end
      dst_if.ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk) begin
    if (rst || (src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    static int unsigned dir_cfg [13][3] = '{
      '{2, 2, 1}, '{640, 480, 1}, '{16, 12, 20}, '{12, 16, 7}, '{640, 2, 640},
      '{2, 480, 640}, '{3, 12, 8}, '{0, 12, 8}, '{700, 12, 8}, '{16, 500, 8},
      '{16, 12, 0}, '{16, 12, 1023}, '{8, 10'h206, 9}};
    int unsigned w, h, s, lim, n, sel, a;
    src_if.valid = 1'b0; src_if.mode = 1'b0; src_if.byte_address = '0;
    src_if.byte_value = '0; src_if.out_x = '0; src_if.out_y = '0;
    dst_if.ready = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_load(STORE_DEPTH - 1, 255);
    push_load(19'h7FFFF, 0);
    push_pixel(0, 0, -1, -1);
    push_pixel(0, 80, 0, 0);
    push_pixel(639, 559, 255, 255);
    push_pixel(320, 300, 255, 0);
    push_pixel(200, 400, 0, 255);
    push_pixel(1023, 1023, -1, -1);
    wait_drained();
    write_reg(REG_NONE, 10'h3FF);
    foreach (dir_cfg[i]) begin
      set_frame(dir_cfg[i][0], dir_cfg[i][1], dir_cfg[i][2]);
      push_pixel(cur_s / 2, cur_s / 2, -1, -1);
      wait_drained();
    end

    while (n_items < TARGET_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
        w = 2 * $urandom_range(1, 16); h = 2 * $urandom_range(1, 12);
        s = $urandom_range(1, 48);
      end else if (sel < 95) begin
        w = ($urandom_range(0, 1) != 0) ? 640 : 2 * $urandom_range(1, 320);
        h = 2 * $urandom_range(1, 240); s = $urandom_range(1, 640);
      end else begin
        w = $urandom_range(0, 1023); h = $urandom_range(0, 1023);
        s = $urandom_range(0, 1023);
      end
      set_frame(w, h, s);
      lim = (cur_s == 0) ? 3 : ((cur_s + 1 > 1023) ? 1023 : cur_s + 1);
      n = $urandom_range(20, 80);
      repeat (n) begin
        if (n_items >= TARGET_ITEMS) break;
        sel = $urandom_range(0, 99);
        if (sel < 68) begin
          push_pixel($urandom_range(0, lim), $urandom_range(0, lim), -1, -1);
        end else if (sel < 75) begin
          push_pixel($urandom_range(0, 1023), $urandom_range(0, 1023), -1, -1);
        end else begin
          a = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 19'h7FFFF) :
              $urandom_range(0, (cur_w * cur_h * 3 / 2) % STORE_DEPTH);
          push_load(a, $urandom_range(0, 255));
        end
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/nlr_pkg.sv
design/nlr_ifs.sv
design/nlr_front.sv
design/nlr_queue.sv
design/nlr_div.sv
design/nlr_back.sv
design/nv12_letterbox_resize_to_rgb.sv
verif/tb_nv12_letterbox_resize_to_rgb.sv
